### src/qdd_pkg.sv
package qdd_pkg;

   typedef enum logic [2:0] {
      KIND_SAMPLE    = 3'd0,
      KIND_SET_POS   = 3'd1,
      KIND_CLR_DELTA = 3'd2,
      KIND_CLR_MOVE  = 3'd3,
      KIND_CLR_DIR   = 3'd4
   } kind_type;

   typedef enum logic [1:0] {
      DIR_NONE = 2'd0,
      DIR_CW   = 2'd1,
      DIR_CCW  = 2'd2
   } dir_type;

   localparam logic [1:0] CSR_REVERSE = 2'd0;
   localparam logic [1:0] CSR_STEPS   = 2'd1;
   localparam logic [6:0] STEPS_RESET = 7'd4;

   typedef struct packed {
      logic              reverse;
      logic [6:0]        steps;
   } cfg_type;

   typedef struct packed {
      logic [2:0]        kind;
      logic              clk_level;
      logic              dt_level;
      logic signed [31:0] new_position;
   } item_type;

   typedef struct packed {
      logic [1:0]        prev_phase;
      logic              primed;
      logic signed [7:0] acc;
      logic [31:0]       position;
      logic [31:0]       delta;
      logic [1:0]        direction;
      logic              movement;
   } state_type;

   typedef struct packed {
      logic signed [1:0] detent_step;
      logic              movement_available;
      logic [1:0]        direction;
      logic signed [31:0] delta;
      logic signed [31:0] position;
   } result_type;

   // index is {old phase, new phase}
   function automatic logic signed [1:0] phase_step(input logic [3:0] idx);
      logic signed [1:0] t;
      case (idx)
         4'd1, 4'd7, 4'd8, 4'd14: t = -2'sd1;
         4'd2, 4'd4, 4'd11, 4'd13: t = 2'sd1;
         default: t = 2'sd0;
      endcase
      return t;
   endfunction

endpackage

### src/qdd_step.sv
module qdd_step
   import qdd_pkg::*;
(
   input  cfg_type    cfg,
   input  item_type   item,
   input  state_type  state,
   output state_type  state_next,
   output result_type result
);

   logic [1:0]        cur;
   logic signed [1:0] t_raw;
   logic signed [1:0] t;
   logic signed [7:0] sum;
   logic signed [7:0] lim;
   logic signed [1:0] step;

   assign cur   = {item.clk_level, item.dt_level};
   assign t_raw = phase_step({state.prev_phase, cur});
   assign t     = cfg.reverse ? -t_raw : t_raw;
   assign sum   = state.acc + {{6{t[1]}}, t};
   assign lim   = {1'b0, cfg.steps};

   always_comb begin
      state_next = state;
      step       = 2'sd0;
      case (item.kind)
         KIND_SAMPLE: begin
            state_next.prev_phase = cur;
            state_next.primed     = 1'b1;
            if (state.primed && t != 2'sd0) begin
               state_next.acc = sum;
               if (sum >= lim) begin
                  state_next.acc       = 8'sd0;
                  state_next.position  = state.position + 32'd1;
                  state_next.delta     = state.delta + 32'd1;
                  state_next.direction = DIR_CW;
                  state_next.movement  = 1'b1;
                  step                 = 2'sd1;
               end else if (sum <= -lim) begin
                  state_next.acc       = 8'sd0;
                  state_next.position  = state.position - 32'd1;
                  state_next.delta     = state.delta - 32'd1;
                  state_next.direction = DIR_CCW;
                  state_next.movement  = 1'b1;
                  step                 = -2'sd1;
               end
            end
         end
         KIND_SET_POS: begin
            state_next.position  = item.new_position;
            state_next.delta     = 32'd0;
            state_next.acc       = 8'sd0;
            state_next.movement  = 1'b0;
            state_next.direction = DIR_NONE;
         end
         KIND_CLR_DELTA: begin
            state_next.delta    = 32'd0;
            state_next.movement = 1'b0;
         end
         KIND_CLR_MOVE: begin
            state_next.delta     = 32'd0;
            state_next.movement  = 1'b0;
            state_next.direction = DIR_NONE;
         end
         KIND_CLR_DIR: begin
            state_next.direction = DIR_NONE;
         end
         default: ;
      endcase
   end

   // samples report state after the update; host items report the new position, old delta/dir/movement
   always_comb begin
      result.position    = state_next.position;
      result.detent_step = step;
      if (item.kind == KIND_SAMPLE) begin
         result.delta              = state_next.delta;
         result.direction          = state_next.direction;
         result.movement_available = state_next.movement;
      end else begin
         result.delta              = state.delta;
         result.direction          = state.direction;
         result.movement_available = state.movement;
      end
   end

endmodule

### src/quadrature_detent_decoder.sv
// A req item passes the input register, then the result register, before rsp_tvalid rises.
// Throughput: one item per cycle unless rsp stalls; decode and counter update sit between the
// input register and the result register, and the decoder state updates as an item leaves it.
// Reset (synchronous, active high): channels empty, counters, phase and direction cleared,
// reverse_direction 0, steps_per_detent 4.
module quadrature_detent_decoder
   import qdd_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [39:0] req_tdata,   // clk_level, dt_level, new_position[31:0], zero pad
   input  logic [2:0]  req_tuser,   // kind
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [71:0] rsp_tdata,   // position, delta, direction, movement_available,
                                    // detent_step, zero pad
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [1:0]  csr_index,
   input  logic [6:0]  csr_data
);

   logic       in_valid_ff;
   item_type   in_item_ff;
   logic       out_valid_ff;
   result_type out_ff;
   state_type  state_ff;
   state_type  state_in;
   cfg_type    cfg_ff;
   result_type result_in;
   logic       advance;
   logic       csr_write;

   assign advance    = in_valid_ff && (!out_valid_ff || rsp_tready);
   assign req_tready = !in_valid_ff || advance;
   assign csr_ready  = 1'b1;
   assign csr_write  = csr_valid && csr_ready;

   qdd_step u_step (
      .cfg        (cfg_ff),
      .item       (in_item_ff),
      .state      (state_ff),
      .state_next (state_in),
      .result     (result_in)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_tready) begin
         in_valid_ff <= req_tvalid;
      end
      if (req_tvalid && req_tready) begin
         in_item_ff.kind         <= req_tuser;
         in_item_ff.clk_level    <= req_tdata[0];
         in_item_ff.dt_level     <= req_tdata[1];
         in_item_ff.new_position <= req_tdata[33:2];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (advance) begin
         out_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         out_valid_ff <= 1'b0;
      end
      if (advance) begin
         out_ff <= result_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= '0;
         cfg_ff.reverse <= 1'b0;
         cfg_ff.steps  <= STEPS_RESET;
      end else begin
         if (advance) begin
            state_ff <= state_in;
         end
         if (csr_write) begin
            case (csr_index)
               CSR_REVERSE: cfg_ff.reverse <= csr_data[0];
               CSR_STEPS: begin
                  cfg_ff.steps <= (csr_data == 7'd0) ? 7'd1 : csr_data;
                  state_ff.acc <= 8'sd0;
               end
               default: ;
            endcase
         end
      end
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = {3'b000, out_ff.detent_step, out_ff.movement_available,
                        out_ff.direction, out_ff.delta, out_ff.position};

   a_acc_range: assert property (@(posedge clock) disable iff (reset)
      state_ff.acc != -8'sd128)
      else $error("transition accumulator out of range");

   a_unprimed_idle: assert property (@(posedge clock) disable iff (reset)
      !state_ff.primed |-> (state_ff.acc == 8'sd0 && state_ff.prev_phase == 2'd0))
      else $error("decoder state moved before first sample");

   a_host_no_step: assert property (@(posedge clock) disable iff (reset)
      advance && in_item_ff.kind != KIND_SAMPLE |=> out_ff.detent_step == 2'sd0)
      else $error("host item produced a detent step");

   a_dir_code: assert property (@(posedge clock) disable iff (reset)
      state_ff.direction != 2'd3)
      else $error("invalid direction code");

   a_stall: assert property (@(posedge clock) disable iff (reset)
      !req_tready |-> (in_valid_ff && out_valid_ff && !rsp_tready))
      else $error("input stalled without downstream backpressure");

endmodule
